// ===== hw/rtl/byte_ring_buffer_core_macros.svh =====
// Assertion helpers used by byte_ring_buffer_core.
`ifndef BYTE_RING_BUFFER_CORE_MACROS_SVH
`define BYTE_RING_BUFFER_CORE_MACROS_SVH

// Check cons in the same cycle as ante.
`define BRB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define BRB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/brb_pkg.sv =====
package brb_pkg;

    localparam int FUNC_W = 2;
    localparam int LEN_W  = 4;
    localparam int DATA_W = 64;
    localparam int FILL_W = 9;
    localparam int BYTE_W = 8;
    localparam int WORD_BYTES = DATA_W / BYTE_W;
    localparam int SEL_W  = 3;

    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_PEEK  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FETCH = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd3;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } lane_ctl_t;

    function automatic logic [BYTE_W-1:0] byte_of(input logic [DATA_W-1:0] word,
                                                  input logic [SEL_W-1:0] sel);
        byte_of = word[sel*BYTE_W +: BYTE_W];
    endfunction

endpackage

// ===== hw/rtl/brb_cmd_if.sv =====
interface brb_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [brb_pkg::FUNC_W-1:0]    func;
    logic [brb_pkg::LEN_W-1:0]     length;
    logic [brb_pkg::DATA_W-1:0]    data_word;

    modport source (output valid, output func, output length, output data_word, input ready);
    modport sink   (input valid, input func, input length, input data_word, output ready);
endinterface

// ===== hw/rtl/brb_rsp_if.sv =====
interface brb_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          ok;
    logic [brb_pkg::DATA_W-1:0]    read_data;
    logic [brb_pkg::FILL_W-1:0]    fill_count;

    modport source (output valid, output ok, output read_data, output fill_count, input ready);
    modport sink   (input valid, input ok, input read_data, input fill_count, output ready);
endinterface

// ===== hw/rtl/brb_lane.sv =====
module brb_lane #(
    parameter int LANES = 8,
    parameter int ROWS  = 32,
    parameter int IDX   = 0
) (
    input  logic                                   clk,
    input  brb_pkg::lane_ctl_t                     ctl,
    input  logic [(LANES > 1 ? $clog2(LANES) : 1)-1:0] base_bank,
    input  logic [(ROWS > 1 ? $clog2(ROWS) : 1)-1:0]   base_row,
    input  logic [(ROWS > 1 ? $clog2(ROWS) : 1)-1:0]   next_row,
    input  logic [brb_pkg::LEN_W-1:0]              length,
    input  logic [brb_pkg::DATA_W-1:0]             data_word,
    output logic [brb_pkg::BYTE_W-1:0]             rd_byte
);
    import brb_pkg::*;

    localparam int BANK_W = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int SUM_W  = BANK_W + 1;

    logic [BYTE_W-1:0] mem [ROWS];
    logic [BYTE_W-1:0] rd_byte_reg;
    logic [SUM_W-1:0]  offset;
    logic              below;
    logic              active;
    logic [ROW_W-1:0]  row;

    // Position of this lane's byte within the transfer.
    assign below  = SUM_W'(IDX) < SUM_W'(base_bank);
    assign offset = below ? SUM_W'(IDX + LANES) - SUM_W'(base_bank)
                          : SUM_W'(IDX) - SUM_W'(base_bank);
    assign active = LEN_W'(offset) < length;
    assign row    = below ? next_row : base_row;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en && active)
        begin
            mem[row] <= byte_of(data_word, SEL_W'(offset));
        end
        if (ctl.rd_en)
        begin
            rd_byte_reg <= mem[row];
        end
    end

    assign rd_byte = rd_byte_reg;

endmodule

// ===== hw/rtl/brb_merge.sv =====
module brb_merge #(
    parameter int LANES = 8
) (
    input  logic [brb_pkg::BYTE_W-1:0]                 lane_byte [LANES],
    input  logic [(LANES > 1 ? $clog2(LANES) : 1)-1:0] base_bank,
    input  logic [brb_pkg::LEN_W-1:0]                  length,
    input  logic                                       show,
    output logic [brb_pkg::DATA_W-1:0]                 read_data
);
    import brb_pkg::*;

    localparam int BANK_W = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int SUM_W  = BANK_W + 1;

    // Rotate the lane bytes so the oldest lands in byte 0; zero the rest.
    for (genvar i = 0; i < WORD_BYTES; i++)
    begin : g_byte
        if (i < LANES)
        begin : g_live
            logic [SUM_W-1:0] raw;
            logic [SUM_W-1:0] src;
            assign raw = SUM_W'(base_bank) + SUM_W'(i);
            assign src = (raw >= SUM_W'(LANES)) ? raw - SUM_W'(LANES) : raw;
            assign read_data[i*BYTE_W +: BYTE_W] =
                (show && (LEN_W'(i) < length)) ? lane_byte[src[BANK_W-1:0]] : '0;
        end
        else
        begin : g_dead
            assign read_data[i*BYTE_W +: BYTE_W] = '0;
        end
    end

endmodule

// ===== hw/rtl/byte_ring_buffer_core.sv =====
// Circular byte FIFO of DEPTH bytes. Each command beat on cmd carries func (write, peek,
// fetch, clear), a length of 1..MAX_XFER bytes and a 64-bit data word whose byte 0 sits in
// bits 7:0; each one produces exactly one response beat on rsp with ok, the bytes read
// (oldest in byte 0, unused bytes zero) and the fill count after the command. A write that
// does not fit, a read of more than is held, or a length of zero or above MAX_XFER is
// refused with no change; clear always succeeds. The storage is MAX_XFER byte lanes, each a
// bank of ceil(DEPTH/MAX_XFER) bytes with one write and one registered read per cycle, so a
// whole transfer touches every bank at most once. A command is taken every cycle and its
// response appears in the cycle after acceptance, set by the lane banks' registered read;
// the queue holds one response, and a new command is taken in the cycle the pending one
// leaves. The banks are not cleared at reset: only bytes written since are ever read back.
`include "byte_ring_buffer_core_macros.svh"

module byte_ring_buffer_core #(
    parameter int DEPTH    = 256,
    parameter int MAX_XFER = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    brb_cmd_if.sink   cmd,
    brb_rsp_if.source rsp
);
    import brb_pkg::*;

    localparam int LANES  = MAX_XFER;
    localparam int ROWS   = (DEPTH + LANES - 1) / LANES;
    localparam int BANK_W = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int SUM_W  = BANK_W + 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Pointers are kept as (row, bank); the bank is the lane that holds the byte.
    logic [BANK_W-1:0] wr_bank_reg, wr_bank_next;
    logic [ROW_W-1:0]  wr_row_reg,  wr_row_next;
    logic [BANK_W-1:0] rd_bank_reg, rd_bank_next;
    logic [ROW_W-1:0]  rd_row_reg,  rd_row_next;
    logic [CNT_W-1:0]  held_reg,    held_next;

    // Response stage.
    logic              rsp_valid_reg;
    logic              ok_reg;
    logic              show_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [BANK_W-1:0] show_bank_reg;
    logic [FILL_W-1:0] fill_reg;

    logic              accept;
    logic              is_write;
    logic              is_read;
    logic              is_fetch;
    logic              is_clear;
    logic              len_ok;
    logic [CNT_W-1:0]  len_cnt;
    logic [CNT_W-1:0]  space;
    logic              wr_fit;
    logic              rd_fit;
    logic              ok;
    logic [SUM_W-1:0]  wr_sum;
    logic [SUM_W-1:0]  rd_sum;
    logic [ROW_W-1:0]  wr_row_inc;
    logic [ROW_W-1:0]  rd_row_inc;
    logic [BANK_W-1:0] base_bank;
    logic [ROW_W-1:0]  base_row;
    logic [ROW_W-1:0]  base_row_inc;
    lane_ctl_t         lane_ctl;
    logic [BYTE_W-1:0] lane_byte [LANES];

    // Take a new command whenever the response slot is free or being drained.
    assign accept    = cmd.valid && cmd.ready;
    assign cmd.ready = !rsp_valid_reg || rsp.ready;

    assign is_write = (cmd.func == FUNC_WRITE);
    assign is_fetch = (cmd.func == FUNC_FETCH);
    assign is_read  = (cmd.func == FUNC_PEEK) || is_fetch;
    assign is_clear = (cmd.func == FUNC_CLEAR);

    assign len_ok  = (cmd.length != '0) && (cmd.length <= LEN_W'(MAX_XFER));
    assign len_cnt = CNT_W'(cmd.length);
    assign space   = CNT_W'(DEPTH) - held_reg;
    assign wr_fit  = len_ok && (len_cnt <= space);
    assign rd_fit  = len_ok && (len_cnt <= held_reg);
    assign ok      = is_clear || (is_write && wr_fit) || (is_read && rd_fit);

    // Row after each pointer's row, with wrap.
    assign wr_row_inc = (wr_row_reg == ROW_W'(ROWS - 1)) ? '0 : wr_row_reg + 1'b1;
    assign rd_row_inc = (rd_row_reg == ROW_W'(ROWS - 1)) ? '0 : rd_row_reg + 1'b1;

    // Advance a pointer by length; length is at most one row of lanes.
    assign wr_sum = SUM_W'(wr_bank_reg) + SUM_W'(cmd.length);
    assign rd_sum = SUM_W'(rd_bank_reg) + SUM_W'(cmd.length);

    always_comb
    begin
        wr_bank_next = wr_bank_reg;
        wr_row_next  = wr_row_reg;
        rd_bank_next = rd_bank_reg;
        rd_row_next  = rd_row_reg;
        held_next    = held_reg;
        if (is_clear)
        begin
            wr_bank_next = '0;
            wr_row_next  = '0;
            rd_bank_next = '0;
            rd_row_next  = '0;
            held_next    = '0;
        end
        else if (is_write && wr_fit)
        begin
            if (wr_sum >= SUM_W'(LANES))
            begin
                wr_bank_next = BANK_W'(wr_sum - SUM_W'(LANES));
                wr_row_next  = wr_row_inc;
            end
            else
            begin
                wr_bank_next = BANK_W'(wr_sum);
            end
            held_next = held_reg + len_cnt;
        end
        else if (is_fetch && rd_fit)
        begin
            if (rd_sum >= SUM_W'(LANES))
            begin
                rd_bank_next = BANK_W'(rd_sum - SUM_W'(LANES));
                rd_row_next  = rd_row_inc;
            end
            else
            begin
                rd_bank_next = BANK_W'(rd_sum);
            end
            held_next = held_reg - len_cnt;
        end
    end

    // Lanes address from the write pointer on writes and the read pointer otherwise.
    assign base_bank    = is_write ? wr_bank_reg : rd_bank_reg;
    assign base_row     = is_write ? wr_row_reg  : rd_row_reg;
    assign base_row_inc = is_write ? wr_row_inc  : rd_row_inc;

    assign lane_ctl.wr_en = accept && is_write && wr_fit;
    assign lane_ctl.rd_en = accept && is_read && rd_fit;

    for (genvar k = 0; k < LANES; k++)
    begin : g_lane
        brb_lane #(
            .LANES (LANES),
            .ROWS  (ROWS),
            .IDX   (k)
        ) u_lane (
            .clk       (clk),
            .ctl       (lane_ctl),
            .base_bank (base_bank),
            .base_row  (base_row),
            .next_row  (base_row_inc),
            .length    (cmd.length),
            .data_word (cmd.data_word),
            .rd_byte   (lane_byte[k])
        );
    end

    // Hold the response fields until the beat leaves; advance them on every accept.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_bank_reg   <= '0;
            wr_row_reg    <= '0;
            rd_bank_reg   <= '0;
            rd_row_reg    <= '0;
            held_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                wr_bank_reg <= wr_bank_next;
                wr_row_reg  <= wr_row_next;
                rd_bank_reg <= rd_bank_next;
                rd_row_reg  <= rd_row_next;
                held_reg    <= held_next;
            end
            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ok_reg        <= ok;
            show_reg      <= is_read && rd_fit;
            len_reg       <= cmd.length;
            show_bank_reg <= rd_bank_reg;
            fill_reg      <= FILL_W'(held_next);
        end
    end

    brb_merge #(
        .LANES (LANES)
    ) u_merge (
        .lane_byte (lane_byte),
        .base_bank (show_bank_reg),
        .length    (len_reg),
        .show      (show_reg),
        .read_data (rsp.read_data)
    );

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.ok         = ok_reg;
    assign rsp.fill_count = fill_reg;

    // The count never passes the capacity.
    `BRB_ASSERT_NOW(a_held_bound, 1'b1, held_reg <= CNT_W'(DEPTH), "held count above depth")
    // A refused command returns no data.
    `BRB_ASSERT_NOW(a_refused_zero, rsp.valid && !rsp.ok, rsp.read_data == '0,
        "refused command returned data")
    // A clear empties the queue and answers with a zero fill count.
    `BRB_ASSERT_NEXT(a_clear_empty, accept && is_clear,
        held_reg == '0 && rsp.valid && rsp.ok && rsp.fill_count == '0,
        "clear did not empty the queue")

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import brb_pkg::*;

    localparam int RING_DEPTH   = 256;
    localparam int XFER_MAX     = 8;
    localparam int RANDOM_ITEMS = 1000;
    localparam int HOLD_CYCLES  = 64;
    localparam logic [DATA_W-1:0] ONES = {DATA_W{1'b1}};

    // One response beat as the block should return it.
    typedef struct packed {
        logic              ok;
        logic [DATA_W-1:0] read_data;
        logic [FILL_W-1:0] fill_count;
    } ring_result_t;

    // One row of the directed table. Rows with check_now set carry a response
    // typed in by hand; the others are checked against the shadow queue.
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [LEN_W-1:0]  length;
        logic [DATA_W-1:0] data_word;
        logic [7:0]        repeats;
        logic              check_now;
        ring_result_t      want;
    } cmd_row_t;

    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN, MIX_NOISE} mix_t;
    typedef enum int {RX_OPEN, RX_COIN, RX_MOSTLY, RX_CADENCE} stall_t;

    localparam int DIRECTED_ROWS = 26;
    localparam cmd_row_t DIRECTED [DIRECTED_ROWS] = '{
        // empty queue: reads are refused
        '{FUNC_FETCH, 4'd1,  64'd0, 8'd1, 1'b1, '{1'b0, 64'd0, 9'd0}},
        '{FUNC_PEEK,  4'd8,  64'd0, 8'd1, 1'b1, '{1'b0, 64'd0, 9'd0}},
        // zero length and lengths above the transfer limit
        '{FUNC_WRITE, 4'd0,  ONES,  8'd1, 1'b1, '{1'b0, 64'd0, 9'd0}},
        '{FUNC_WRITE, 4'd8,  64'h0123_4567_89AB_CDEF, 8'd1, 1'b1, '{1'b1, 64'd0, 9'd8}},
        '{FUNC_WRITE, 4'd9,  ONES,  8'd1, 1'b1, '{1'b0, 64'd0, 9'd8}},
        '{FUNC_WRITE, 4'd15, ONES,  8'd1, 1'b1, '{1'b0, 64'd0, 9'd8}},
        // peek leaves the bytes, fetch takes them, oldest byte lowest
        '{FUNC_PEEK,  4'd8,  64'd0, 8'd1, 1'b1, '{1'b1, 64'h0123_4567_89AB_CDEF, 9'd8}},
        '{FUNC_PEEK,  4'd4,  ONES,  8'd1, 1'b1, '{1'b1, 64'h0000_0000_89AB_CDEF, 9'd8}},
        '{FUNC_FETCH, 4'd3,  64'd0, 8'd1, 1'b1, '{1'b1, 64'h0000_0000_00AB_CDEF, 9'd5}},
        '{FUNC_FETCH, 4'd0,  64'd0, 8'd1, 1'b1, '{1'b0, 64'd0, 9'd5}},
        '{FUNC_PEEK,  4'd6,  64'd0, 8'd1, 1'b1, '{1'b0, 64'd0, 9'd5}},
        '{FUNC_FETCH, 4'd5,  64'd0, 8'd1, 1'b1, '{1'b1, 64'h0000_0001_2345_6789, 9'd0}},
        // clear ignores its length and data
        '{FUNC_WRITE, 4'd8,  ONES,  8'd1, 1'b1, '{1'b1, 64'd0, 9'd8}},
        '{FUNC_CLEAR, 4'd15, ONES,  8'd1, 1'b1, '{1'b1, 64'd0, 9'd0}},
        '{FUNC_PEEK,  4'd1,  64'd0, 8'd1, 1'b1, '{1'b0, 64'd0, 9'd0}},
        '{FUNC_WRITE, 4'd1,  64'hFFFF_FFFF_FFFF_FF5A, 8'd1, 1'b1, '{1'b1, 64'd0, 9'd1}},
        '{FUNC_PEEK,  4'd1,  64'd0, 8'd1, 1'b1, '{1'b1, 64'h5A, 9'd1}},
        '{FUNC_CLEAR, 4'd0,  64'd0, 8'd1, 1'b1, '{1'b1, 64'd0, 9'd0}},
        // fill to the brim, then a write that does not fit
        '{FUNC_WRITE, 4'd8,  64'hC3A5_0F1E_2D3C_4B5A, 8'd32, 1'b0, '0},
        '{FUNC_WRITE, 4'd1,  ONES,  8'd1, 1'b1, '{1'b0, 64'd0, 9'd256}},
        '{FUNC_PEEK,  4'd8,  64'd0, 8'd1, 1'b0, '0},
        // drain almost all, refill and read across the pointer wrap
        '{FUNC_FETCH, 4'd8,  64'd0, 8'd31, 1'b0, '0},
        '{FUNC_WRITE, 4'd8,  64'hFEDC_BA98_7654_3210, 8'd4, 1'b0, '0},
        '{FUNC_FETCH, 4'd8,  64'd0, 8'd2, 1'b0, '0},
        '{FUNC_FETCH, 4'd15, 64'd0, 8'd1, 1'b1, '{1'b0, 64'd0, 9'd24}},
        '{FUNC_CLEAR, 4'd8,  ONES,  8'd1, 1'b1, '{1'b1, 64'd0, 9'd0}}
    };

    logic clk;
    logic rst_n = 1'b0;

    brb_cmd_if cmd_bus ();
    brb_rsp_if rsp_bus ();

    byte_ring_buffer_core #(
        .DEPTH    (RING_DEPTH),
        .MAX_XFER (XFER_MAX)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .rsp   (rsp_bus)
    );

    // Shadow copy of the queue, advanced once per accepted command beat.
    logic [BYTE_W-1:0] shadow_bytes [RING_DEPTH];
    int                shadow_rd;
    int                shadow_wr;
    int                shadow_held;

    ring_result_t expected_rsp [$];
    int           mismatch_count;

    // Sender pacing and the handshake with the receiver's long hold-off.
    int unsigned burst_left;
    bit          steady;
    bit          flood;
    bit          hold_done;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Give up on a hung block: the slowest correct run is far below this.
    initial begin
        #3_000_000;
        $display("FAIL byte_ring_buffer_core");
        $finish;
    end

    task automatic flag_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Apply one command to the shadow queue and return the response it earns.
    function automatic ring_result_t ring_apply(input logic [FUNC_W-1:0] func,
                                                input logic [LEN_W-1:0]  length,
                                                input logic [DATA_W-1:0] data_word);
        ring_result_t r;
        bit           len_legal;
        int           n;
        int           i;
        r = '0;
        n = int'(length);
        len_legal = (n != 0) && (n <= XFER_MAX);
        case (func)
            FUNC_CLEAR:
            begin
                // drop pointers and count, keep the stored bytes
                shadow_rd   = 0;
                shadow_wr   = 0;
                shadow_held = 0;
                r.ok        = 1'b1;
            end
            FUNC_WRITE:
            begin
                if (len_legal && n <= RING_DEPTH - shadow_held)
                begin
                    for (i = 0; i < n; i++)
                        shadow_bytes[(shadow_wr + i) % RING_DEPTH] = data_word[i*BYTE_W +: BYTE_W];
                    shadow_wr    = (shadow_wr + n) % RING_DEPTH;
                    shadow_held += n;
                    r.ok         = 1'b1;
                end
            end
            default:
            begin
                if (len_legal && shadow_held >= n)
                begin
                    for (i = 0; i < n; i++)
                        r.read_data[i*BYTE_W +: BYTE_W] = shadow_bytes[(shadow_rd + i) % RING_DEPTH];
                    if (func == FUNC_FETCH)
                    begin
                        shadow_rd    = (shadow_rd + n) % RING_DEPTH;
                        shadow_held -= n;
                    end
                    r.ok = 1'b1;
                end
            end
        endcase
        r.fill_count = shadow_held[FILL_W-1:0];
        return r;
    endfunction

    // Offer one command beat, honoring the burst/gap pacing, and hold it until
    // the block takes it. Record the response it must produce.
    task automatic offer_cmd(input logic [FUNC_W-1:0] func,
                             input logic [LEN_W-1:0]  length,
                             input logic [DATA_W-1:0] data_word,
                             input bit                use_typed,
                             input ring_result_t      typed_rsp);
        ring_result_t predicted;
        int unsigned  gap;
        if (burst_left == 0)
        begin
            gap = steady ? 0 : $urandom_range(0, 6);
            if (gap != 0)
            begin
                cmd_bus.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        cmd_bus.valid     <= 1'b1;
        cmd_bus.func      <= func;
        cmd_bus.length    <= length;
        cmd_bus.data_word <= data_word;
        @(posedge clk);
        while (!cmd_bus.ready)
            @(posedge clk);
        predicted = ring_apply(func, length, data_word);
        expected_rsp.push_back(use_typed ? typed_rsp : predicted);
    endtask

    // Response side: compare every accepted beat with the oldest expectation.
    always @(posedge clk)
    begin
        ring_result_t want;
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            if (expected_rsp.size() == 0)
                flag_mismatch("response beat with nothing outstanding");
            else
            begin
                want = expected_rsp.pop_front();
                if (rsp_bus.ok !== want.ok)
                    flag_mismatch($sformatf("ok %b, want %b", rsp_bus.ok, want.ok));
                if (rsp_bus.read_data !== want.read_data)
                    flag_mismatch($sformatf("read_data %h, want %h",
                                            rsp_bus.read_data, want.read_data));
                if (rsp_bus.fill_count !== want.fill_count)
                    flag_mismatch($sformatf("fill_count %0d, want %0d",
                                            rsp_bus.fill_count, want.fill_count));
            end
        end
    end

    // Receiver: stall on its own changing pattern; once, while the sender
    // floods, hold ready low long enough that the block backs up its input.
    initial
    begin : rsp_side
        stall_t      kind;
        int          span;
        int          k;
        int unsigned beat_phase;
        rsp_bus.ready <= 1'b0;
        beat_phase = 0;
        @(posedge rst_n);
        forever
        begin
            kind = stall_t'($urandom_range(0, 3));
            span = $urandom_range(16, 96);
            for (k = 0; k < span; k++)
            begin
                @(posedge clk);
                if (flood && !hold_done)
                begin
                    rsp_bus.ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge clk);
                    hold_done = 1'b1;
                end
                beat_phase++;
                case (kind)
                    RX_OPEN:    rsp_bus.ready <= 1'b1;
                    RX_COIN:    rsp_bus.ready <= ($urandom_range(0, 1) == 1);
                    RX_MOSTLY:  rsp_bus.ready <= ($urandom_range(0, 9) < 8);
                    RX_CADENCE: rsp_bus.ready <= (beat_phase % 5 != 4);
                    default:    rsp_bus.ready <= 1'b1;
                endcase
            end
        end
    end

    // Command side: reset, directed table, shaped random traffic, drain.
    initial
    begin : cmd_side
        int                r;
        int                j;
        int                issued;
        int                seg_len;
        int                spin;
        int unsigned       roll;
        mix_t              mix;
        logic [FUNC_W-1:0] func;
        logic [LEN_W-1:0]  length;
        logic [DATA_W-1:0] data_word;

        cmd_bus.valid     <= 1'b0;
        cmd_bus.func      <= FUNC_WRITE;
        cmd_bus.length    <= '0;
        cmd_bus.data_word <= '0;
        mismatch_count = 0;
        shadow_rd      = 0;
        shadow_wr      = 0;
        shadow_held    = 0;
        burst_left     = 0;
        steady         = 1'b0;
        flood          = 1'b0;
        hold_done      = 1'b0;
        for (j = 0; j < RING_DEPTH; j++)
            shadow_bytes[j] = '0;

        // Hold reset, then release on an edge.
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table.
        for (r = 0; r < DIRECTED_ROWS; r++)
            for (j = 0; j < int'(DIRECTED[r].repeats); j++)
                offer_cmd(DIRECTED[r].func, DIRECTED[r].length, DIRECTED[r].data_word,
                          DIRECTED[r].check_now, DIRECTED[r].want);

        // Random traffic in segments: mostly legal commands, some biased toward
        // filling or draining so the count sweeps empty to full, plus noise.
        issued = 0;
        while (issued < RANDOM_ITEMS)
        begin
            roll    = $urandom_range(0, 7);
            mix     = (roll < 2) ? MIX_FILL : (roll < 4) ? MIX_DRAIN :
                      (roll < 7) ? MIX_EVEN : MIX_NOISE;
            seg_len = $urandom_range(8, 64);
            steady  = ($urandom_range(0, 3) == 0);
            if (!hold_done && !flood && issued > 400)
            begin
                // back-to-back beats against a stalled receiver
                flood   = 1'b1;
                steady  = 1'b1;
                mix     = MIX_EVEN;
                seg_len = 48;
            end
            for (j = 0; j < seg_len; j++)
            begin
                roll      = $urandom_range(0, 99);
                data_word = {$urandom, $urandom};
                length    = ($urandom_range(0, 2) == 0) ? 4'(XFER_MAX)
                                                        : 4'($urandom_range(1, XFER_MAX));
                case (mix)
                    MIX_FILL:
                        func = (roll < 2)  ? FUNC_CLEAR : (roll < 74) ? FUNC_WRITE :
                               (roll < 86) ? FUNC_PEEK  : FUNC_FETCH;
                    MIX_DRAIN:
                        func = (roll < 2)  ? FUNC_CLEAR : (roll < 24) ? FUNC_WRITE :
                               (roll < 40) ? FUNC_PEEK  : FUNC_FETCH;
                    MIX_EVEN:
                        func = (roll < 2)  ? FUNC_CLEAR : (roll < 50) ? FUNC_WRITE :
                               (roll < 64) ? FUNC_PEEK  : FUNC_FETCH;
                    default:
                    begin
                        func   = FUNC_W'($urandom_range(0, 3));
                        length = LEN_W'($urandom_range(0, 15));
                    end
                endcase
                offer_cmd(func, length, data_word, 1'b0, '0);
                issued++;
            end
            if (flood)
            begin
                // release only once the receiver has finished its hold-off
                while (!hold_done)
                    @(posedge clk);
                flood = 1'b0;
            end
        end

        cmd_bus.valid <= 1'b0;

        // Drain: wait for every outstanding response, then check that none is left.
        for (spin = 0; spin < 20000 && expected_rsp.size() != 0; spin++)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (expected_rsp.size() != 0)
            flag_mismatch($sformatf("%0d responses never arrived", expected_rsp.size()));

        if (mismatch_count == 0)
            $display("PASS byte_ring_buffer_core");
        else
            $display("FAIL byte_ring_buffer_core");
        $finish;
    end

endmodule
